FILE: rtl/stlf_pkg.sv
// Package for the slot table core: parameters, payload structs, codes.
// No dependencies.
package stlf_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int NAME_CHARS_DEF = 8;

    localparam logic [2:0] REQ_ADD_AUTO  = 3'd0;
    localparam logic [2:0] REQ_ADD_GIVEN = 3'd1;
    localparam logic [2:0] REQ_DELETE    = 3'd2;
    localparam logic [2:0] REQ_SET_ACT   = 3'd3;
    localparam logic [2:0] REQ_GET_ID    = 3'd4;
    localparam logic [2:0] REQ_GET_RANK  = 3'd5;
    localparam logic [2:0] REQ_RANK_OF   = 3'd6;
    localparam logic [2:0] REQ_CLEAR     = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  entry_id;
        logic [7:0]  rank;
        logic [63:0] name_chars;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  result_id;
        logic [5:0]  result_rank;
        logic [63:0] result_name;
        logic [6:0]  entry_count;
        logic [6:0]  active_id;
    } t_rsp;

    // Token passed cell to cell each scan cycle.
    typedef struct packed {
        logic [6:0]  seen;       // used slots passed so far
        logic        found;      // matching slot met
        logic [6:0]  hit_id;
        logic [5:0]  hit_rank;
        logic [63:0] hit_name;
        logic        free_found; // first free slot met
        logic        first_used; // first used slot met
        logic [6:0]  first_id;
        logic [63:0] id_taken;   // bit k: id k+1 held
    } t_tok;

    // Command broadcast to every cell.
    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  key_id;
        logic [7:0]  key_rank;
        logic [63:0] name;
        logic [6:0]  new_id;
        logic        do_write;   // write phase: commit
        logic        do_clear;
    } t_cmd;

endpackage

FILE: rtl/stlf_cell.sv
// One slot of the table; shifts the scan token in a ring with its neighbors.
// Depends on stlf_pkg.
module stlf_cell #(
    parameter int SLOTS = stlf_pkg::SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_tok_en,
    input  stlf_pkg::t_cmd   i_cmd,
    input  logic             i_sel,      // this cell is the slot selected for write-back
    input  stlf_pkg::t_tok   i_tok,
    output stlf_pkg::t_tok   o_tok,
    output logic             o_used,
    output logic [6:0]       o_id
);
    logic        r_used;
    logic [6:0]  r_id;
    logic [63:0] r_name;
    stlf_pkg::t_tok r_tok;
    stlf_pkg::t_tok n_tok;
    logic        w_match;
    logic        w_rkmatch;

    assign w_match   = r_used && (r_id == i_cmd.key_id);
    assign w_rkmatch = r_used && ({1'b0, i_tok.seen} == i_cmd.key_rank);

    always_comb begin
        n_tok = i_tok;
        if (i_tok_en) begin
            if (r_used) begin
                if (!i_tok.first_used) begin
                    n_tok.first_used = 1'b1;
                    n_tok.first_id   = r_id;
                end
                if (r_id != 7'd0 && r_id <= 7'(SLOTS))
                    n_tok.id_taken[6'(r_id - 7'd1)] = 1'b1;
            end else begin
                n_tok.free_found = 1'b1;
            end
            if (!i_tok.found) begin
                if ((i_cmd.op == stlf_pkg::REQ_GET_RANK) ? w_rkmatch : w_match) begin
                    n_tok.found    = 1'b1;
                    n_tok.hit_id   = r_id;
                    n_tok.hit_rank = i_tok.seen[5:0];
                    n_tok.hit_name = r_name;
                end else if (r_used) begin
                    n_tok.seen = i_tok.seen + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_id   <= '0;
        end else if (i_cmd.do_clear) begin
            r_used <= 1'b0;
            r_id   <= '0;
        end else if (i_cmd.do_write && i_sel) begin
            if (i_cmd.op == stlf_pkg::REQ_DELETE) begin
                r_used <= 1'b0;
                r_id   <= '0;
            end else begin
                r_used <= 1'b1;
                r_id   <= i_cmd.new_id;
                r_name <= i_cmd.name;
            end
        end
        if (i_shift) r_tok <= n_tok;
    end

    assign o_tok  = r_tok;
    assign o_used = r_used;
    assign o_id   = r_id;
endmodule

FILE: rtl/slot_table_lowest_free_id_core.sv
// Top level of the slot table core: sequencer plus the row of slot cells.
// Depends on stlf_pkg and stlf_cell.
//
//  channel | dir | signals                          | payload
//  request | in  | i_req_valid, o_req_stall, i_req  | stlf_pkg::t_req
//  result  | out | o_rsp_valid, i_rsp_stall, o_rsp  | stlf_pkg::t_rsp
//
// Each command is loaded on accept, then the scan token walks the cell chain
// slot by slot in the scan state, then the done state decides and writes back.
// The result is valid the cycle after the decide cycle.
// One command at a time; request stalls while a command is in flight. The
// result waits in the output register; the decide cycle holds only while an
// earlier result is still stalled there.
// Reset (synchronous, active low) empties all slots, count and active id.
module slot_table_lowest_free_id_core #(
    parameter int SLOTS      = stlf_pkg::SLOTS_DEF,
    parameter int NAME_CHARS = stlf_pkg::NAME_CHARS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  stlf_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output stlf_pkg::t_rsp  o_rsp
);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_pos;    // slot index under the token
    stlf_pkg::t_req r_req;
    logic [63:0] r_name;
    logic r_blank;
    logic [6:0] r_used_cnt;
    logic [6:0] r_active;
    logic r_rsp_valid;
    stlf_pkg::t_rsp r_rsp;

    stlf_pkg::t_tok w_tok [SLOTS+1];
    stlf_pkg::t_tok w_tok_in;
    stlf_pkg::t_cmd w_cmd;
    logic [SLOTS-1:0] w_used;
    logic [6:0] w_id [SLOTS];
    logic [SLOTS-1:0] w_sel;
    logic [63:0] w_trim;
    logic w_blank;
    logic w_blank_q;
    logic [IW-1:0] w_free_idx;
    logic w_free_ok;
    logic [6:0] w_low_id;
    logic [6:0] w_key;
    logic w_key_ok;
    stlf_pkg::t_tok w_fin;
    stlf_pkg::t_rsp n_rsp;
    logic [6:0] n_used_cnt;
    logic [6:0] n_active;
    logic w_commit;
    logic [IW-1:0] w_wr_idx;
    logic w_done_go;

    // Trim the incoming name: keep bytes up to first zero, within NAME_CHARS.
    always_comb begin
        logic stop;
        stop   = 1'b0;
        w_trim = '0;
        w_blank = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b < NAME_CHARS && !stop && i_req.name_chars[8*b +: 8] != 8'd0)
                w_trim[8*b +: 8] = i_req.name_chars[8*b +: 8];
            else
                stop = 1'b1;
        end
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (!stop) begin
                if (w_trim[8*b +: 8] == 8'd0) stop = 1'b1;
                else if (w_trim[8*b +: 8] != stlf_pkg::CHAR_SPACE) w_blank = 1'b0;
            end
        end
    end

    assign w_blank_q = r_blank;

    // Decide only when the output register is free or being drained.
    assign w_done_go = (r_state == S_DONE) && (!r_rsp_valid || !i_rsp_stall);

    // Token enters cell 0 fresh on the first scan cycle, then rides the ring.
    always_comb begin
        w_tok_in = w_tok[SLOTS];
        if (r_cnt == '0) w_tok_in = '0;
    end
    assign w_tok[0] = w_tok_in;

    assign w_key_ok = (r_req.entry_id != 8'd0) && ({1'b0, r_req.entry_id} <= 9'(SLOTS));
    assign w_key    = r_req.entry_id[6:0];

    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = r_req.req_type;
        w_cmd.key_id   = (r_req.entry_id[7]) ? 7'h7f : w_key;
        w_cmd.key_rank = r_req.rank;
        w_cmd.name     = r_name;
        w_cmd.new_id   = (r_req.req_type == stlf_pkg::REQ_ADD_AUTO) ? w_low_id : w_key;
        w_cmd.do_write = w_commit;
        w_cmd.do_clear = w_done_go && (r_req.req_type == stlf_pkg::REQ_CLEAR);
    end
    // entry_id of 128..255 must never match: id 127 is never stored.

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign w_sel[g] = (w_wr_idx == IW'(g));
        stlf_cell #(.SLOTS(SLOTS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_state == S_SCAN),
            .i_tok_en(r_pos == IW'(g)),
            .i_cmd   (w_cmd),
            .i_sel   (w_sel[g]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_used  (w_used[g]),
            .o_id    (w_id[g])
        );
    end

    // Final token sits in the last cell once the scan ends.
    assign w_fin = w_tok[SLOTS];

    // First free slot: find after scan via priority encoder over used bits.
    always_comb begin
        w_free_idx = '0;
        w_free_ok  = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--)
            if (!w_used[k]) begin
                w_free_idx = IW'(k);
                w_free_ok  = 1'b1;
            end
    end

    always_comb begin
        w_low_id = 7'd0;
        for (int k = SLOTS - 1; k >= 0; k--)
            if (!w_fin.id_taken[k]) w_low_id = 7'(k + 1);
    end

    // Slot to write: free slot for adds, slot holding the id for delete.
    always_comb begin
        w_wr_idx = w_free_idx;
        if (r_req.req_type == stlf_pkg::REQ_DELETE)
            for (int k = SLOTS - 1; k >= 0; k--)
                if (w_used[k] && w_id[k] == w_cmd.key_id) w_wr_idx = IW'(k);
    end

    // Decide the outcome in the done cycle.
    always_comb begin
        n_rsp      = '0;
        n_used_cnt = r_used_cnt;
        n_active   = r_active;
        w_commit   = 1'b0;
        if (w_done_go) begin
            unique case (r_req.req_type)
                stlf_pkg::REQ_ADD_AUTO, stlf_pkg::REQ_ADD_GIVEN: begin
                    if (w_blank_q) n_rsp.status = stlf_pkg::ST_EMPTY;
                    else if (r_req.req_type == stlf_pkg::REQ_ADD_GIVEN && !w_key_ok)
                        n_rsp.status = stlf_pkg::ST_FULL;
                    else if (r_used_cnt >= 7'(SLOTS) || !w_free_ok)
                        n_rsp.status = stlf_pkg::ST_FULL;
                    else if (r_req.req_type == stlf_pkg::REQ_ADD_GIVEN && w_fin.found)
                        n_rsp.status = stlf_pkg::ST_FULL;
                    else if (r_req.req_type == stlf_pkg::REQ_ADD_AUTO && w_low_id == 7'd0)
                        n_rsp.status = stlf_pkg::ST_FULL;
                    else begin
                        w_commit        = 1'b1;
                        n_rsp.result_id = w_cmd.new_id;
                        n_used_cnt      = r_used_cnt + 7'd1;
                        if (r_req.req_type == stlf_pkg::REQ_ADD_AUTO && r_active == 7'd0)
                            n_active = w_cmd.new_id;
                    end
                end
                stlf_pkg::REQ_DELETE: begin
                    if (!w_fin.found) n_rsp.status = stlf_pkg::ST_MISSING;
                    else begin
                        w_commit = 1'b1;
                        if (r_used_cnt != 7'd0) n_used_cnt = r_used_cnt - 7'd1;
                        if ({1'b0, r_active} == r_req.entry_id) begin
                            // first used slot other than the deleted one
                            n_active = 7'd0;
                            for (int k = SLOTS - 1; k >= 0; k--)
                                if (w_used[k] && IW'(k) != w_wr_idx) n_active = w_id[k];
                        end
                    end
                end
                stlf_pkg::REQ_SET_ACT: begin
                    if (!w_fin.found) n_rsp.status = stlf_pkg::ST_MISSING;
                    else n_active = w_key;
                end
                stlf_pkg::REQ_GET_ID, stlf_pkg::REQ_GET_RANK: begin
                    if (!w_fin.found) n_rsp.status = stlf_pkg::ST_MISSING;
                    else begin
                        n_rsp.result_id   = w_fin.hit_id;
                        n_rsp.result_name = w_fin.hit_name;
                    end
                end
                stlf_pkg::REQ_RANK_OF: begin
                    if (!w_fin.found) n_rsp.status = stlf_pkg::ST_MISSING;
                    else begin
                        n_rsp.result_id   = w_fin.hit_id;
                        n_rsp.result_rank = w_fin.hit_rank;
                    end
                end
                stlf_pkg::REQ_CLEAR: begin
                    n_used_cnt = 7'd0;
                    n_active   = 7'd0;
                end
                default: ;
            endcase
            n_rsp.entry_count = n_used_cnt;
            n_rsp.active_id   = n_active;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_used_cnt  <= '0;
            r_active    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // load a fresh result, or drop the one just taken
            if (w_done_go) r_rsp_valid <= 1'b1;
            else if (r_rsp_valid && !i_rsp_stall) r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && !o_req_stall) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_pos   <= '0;
                    end
                end
                S_SCAN: begin
                    // advance the token one cell per cycle
                    r_cnt <= r_cnt + CW'(1);
                    if (r_pos != IW'(SLOTS - 1)) r_pos <= r_pos + IW'(1);
                    if (r_cnt == CW'(SLOTS - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold while the previous result is still stalled
                    if (w_done_go) begin
                        r_used_cnt <= n_used_cnt;
                        r_active   <= n_active;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid && !o_req_stall) begin
            r_req   <= i_req;
            r_name  <= w_trim;
            r_blank <= w_blank;
        end
        if (w_done_go) r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_req_stall) else $error("accept while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= 7'(SLOTS)) else $error("count overflow");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_rsp_valid) else $error("result lost");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled result changed");
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_used_cnt} == 8'($countones(w_used))))
        else $error("count mismatch");
endmodule

FILE: verif/tb_slot_table_lowest_free_id_core.sv
// Self-checking bench for slot_table_lowest_free_id_core: directed command table, then
// random command streams, every response checked against a behavioral slot table.
// Depends on stlf_pkg and the core RTL.
module tb_slot_table_lowest_free_id_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = stlf_pkg::SLOTS_DEF;
    localparam int LIMIT_CYC  = 400000;
    localparam int N_RANDOM   = 1030;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_stall;
    stlf_pkg::t_req req = '0;
    logic   rsp_valid;
    logic   rsp_stall = 1'b0;
    stlf_pkg::t_rsp rsp;

    // Idle pressure, in percent, for each side; changed between phases.
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    int     cycle_cnt = 0;
    int     mismatch_cnt = 0;

    // Shadow copy of the slot table.
    logic        tbl_used [NSLOT];
    logic [6:0]  tbl_id   [NSLOT];
    logic [63:0] tbl_name [NSLOT];
    logic [6:0]  tbl_count;
    logic [6:0]  tbl_active;

    stlf_pkg::t_rsp pending_rsp [$];

    always #4 clk = ~clk;

    slot_table_lowest_free_id_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    function automatic void table_clear();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_id[i]   = '0;
            tbl_name[i] = '0;
        end
        tbl_count  = '0;
        tbl_active = '0;
    endfunction

    function automatic int slot_of_id(logic [7:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i] && {1'b0, tbl_id[i]} == id) return i;
        return -1;
    endfunction

    // Apply one command to the shadow table and return the response it must produce.
    function automatic stlf_pkg::t_rsp table_apply(stlf_pkg::t_req r);
        stlf_pkg::t_rsp o;
        logic [63:0] nm;
        logic        blank;
        logic [7:0]  new_id;
        int          s;
        int          seen;
        o = '0;
        o.status = stlf_pkg::ST_OK;
        nm = '0;
        for (int i = 0; i < stlf_pkg::NAME_CHARS_DEF; i++) begin
            if (r.name_chars[8*i +: 8] == 8'h00) break;
            nm[8*i +: 8] = r.name_chars[8*i +: 8];
        end
        blank = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (nm[8*i +: 8] == 8'h00) break;
            if (nm[8*i +: 8] != stlf_pkg::CHAR_SPACE) blank = 1'b0;
        end
        case (r.req_type)
            stlf_pkg::REQ_ADD_AUTO, stlf_pkg::REQ_ADD_GIVEN: begin
                new_id = '0;
                if (blank) o.status = stlf_pkg::ST_EMPTY;
                else if (r.req_type == stlf_pkg::REQ_ADD_GIVEN
                         && (r.entry_id == 0 || r.entry_id > NSLOT))
                    o.status = stlf_pkg::ST_FULL;
                else if (tbl_count >= NSLOT) o.status = stlf_pkg::ST_FULL;
                else if (r.req_type == stlf_pkg::REQ_ADD_GIVEN) begin
                    if (slot_of_id(r.entry_id) >= 0) o.status = stlf_pkg::ST_FULL;
                    else new_id = r.entry_id;
                end else begin
                    for (int k = 1; k <= NSLOT; k++)
                        if (slot_of_id(8'(k)) < 0) begin
                            new_id = 8'(k);
                            break;
                        end
                    if (new_id == 0) o.status = stlf_pkg::ST_FULL;
                end
                if (o.status == stlf_pkg::ST_OK) begin
                    s = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (!tbl_used[i]) begin
                            s = i;
                            break;
                        end
                    if (s < 0) o.status = stlf_pkg::ST_FULL;
                    else begin
                        tbl_used[s] = 1'b1;
                        tbl_id[s]   = new_id[6:0];
                        tbl_name[s] = nm;
                        tbl_count++;
                        if (r.req_type == stlf_pkg::REQ_ADD_AUTO && tbl_active == 0)
                            tbl_active = new_id[6:0];
                        o.result_id = new_id[6:0];
                    end
                end
            end
            stlf_pkg::REQ_DELETE: begin
                s = slot_of_id(r.entry_id);
                if (s < 0) o.status = stlf_pkg::ST_MISSING;
                else begin
                    tbl_used[s] = 1'b0;
                    tbl_id[s]   = '0;
                    tbl_name[s] = '0;
                    if (tbl_count > 0) tbl_count--;
                    // Move active to the first remaining record.
                    if ({1'b0, tbl_active} == r.entry_id) begin
                        tbl_active = '0;
                        for (int i = 0; i < NSLOT; i++)
                            if (tbl_used[i]) begin
                                tbl_active = tbl_id[i];
                                break;
                            end
                    end
                end
            end
            stlf_pkg::REQ_SET_ACT: begin
                if (slot_of_id(r.entry_id) < 0) o.status = stlf_pkg::ST_MISSING;
                else tbl_active = r.entry_id[6:0];
            end
            stlf_pkg::REQ_GET_ID: begin
                s = slot_of_id(r.entry_id);
                if (s < 0) o.status = stlf_pkg::ST_MISSING;
                else begin
                    o.result_id   = tbl_id[s];
                    o.result_name = tbl_name[s];
                end
            end
            stlf_pkg::REQ_GET_RANK: begin
                o.status = stlf_pkg::ST_MISSING;
                seen = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_used[i]) begin
                        if (seen == r.rank) begin
                            o.status      = stlf_pkg::ST_OK;
                            o.result_id   = tbl_id[i];
                            o.result_name = tbl_name[i];
                            break;
                        end
                        seen++;
                    end
            end
            stlf_pkg::REQ_RANK_OF: begin
                o.status = stlf_pkg::ST_MISSING;
                seen = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_used[i]) begin
                        if ({1'b0, tbl_id[i]} == r.entry_id) begin
                            o.status      = stlf_pkg::ST_OK;
                            o.result_id   = tbl_id[i];
                            o.result_rank = 6'(seen);
                            break;
                        end
                        seen++;
                    end
            end
            default: table_clear();
        endcase
        o.entry_count = tbl_count;
        o.active_id   = tbl_active;
        return o;
    endfunction

    // Random name: mostly printable, sometimes blank, padded, or full 64-bit noise.
    function automatic logic [63:0] pick_name();
        logic [63:0] nm;
        int          len;
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return '0;
            2: begin
                nm = '0;
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++) nm[8*i +: 8] = stlf_pkg::CHAR_SPACE;
                if ($urandom_range(1))
                    for (int i = len; i < 8; i++) nm[8*i +: 8] = 8'($urandom);
                return nm;
            end
            default: begin
                nm = '0;
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'($urandom_range(126, 33));
                return nm;
            end
        endcase
    endfunction

    function automatic stlf_pkg::t_req pick_req();
        stlf_pkg::t_req r;
        int   roll;
        roll = $urandom_range(99);
        r.name_chars = pick_name();
        r.rank       = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(17));
        r.entry_id   = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(NSLOT + 1));
        // Bias toward adds so the table fills; clears are rare so depth is reached.
        if (roll < 30)      r.req_type = stlf_pkg::REQ_ADD_AUTO;
        else if (roll < 45) r.req_type = stlf_pkg::REQ_ADD_GIVEN;
        else if (roll < 60) r.req_type = stlf_pkg::REQ_DELETE;
        else if (roll < 68) r.req_type = stlf_pkg::REQ_SET_ACT;
        else if (roll < 78) r.req_type = stlf_pkg::REQ_GET_ID;
        else if (roll < 88) r.req_type = stlf_pkg::REQ_GET_RANK;
        else if (roll < 98) r.req_type = stlf_pkg::REQ_RANK_OF;
        else                r.req_type = stlf_pkg::REQ_CLEAR;
        return r;
    endfunction

    // Push one transfer through the request channel; check on the expectation if given.
    task automatic send_req(stlf_pkg::t_req r, logic has_fixed, stlf_pkg::t_rsp fixed);
        stlf_pkg::t_rsp exp_rsp;
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        exp_rsp = table_apply(r);
        if (has_fixed && exp_rsp != fixed) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("table row disagrees with shadow table: row %h shadow %h",
                         fixed, exp_rsp);
        end
        pending_rsp.push_back(exp_rsp);
        req       = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    // Receiver: stall at random on the falling edge, check at the rising edge.
    always @(negedge clk) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected transfer: %p", rsp);
            end else begin
                stlf_pkg::t_rsp e;
                e = pending_rsp.pop_front();
                if (rsp !== e) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: exp st=%0d id=%0d rk=%0d nm=%h cnt=%0d act=%0d",
                                 e.status, e.result_id, e.result_rank, e.result_name,
                                 e.entry_count, e.active_id);
                        $display("          got st=%0d id=%0d rk=%0d nm=%h cnt=%0d act=%0d",
                                 rsp.status, rsp.result_id, rsp.result_rank,
                                 rsp.result_name, rsp.entry_count, rsp.active_id);
                    end
                end
            end
        end
        if (cycle_cnt > LIMIT_CYC) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    typedef struct {
        stlf_pkg::t_req r;
        logic has_fixed;
        stlf_pkg::t_rsp fixed;
    } t_row;

    function automatic stlf_pkg::t_req mk(logic [2:0] op, logic [7:0] id, logic [7:0] rk,
                                          logic [63:0] nm);
        stlf_pkg::t_req r;
        r.req_type = op;
        r.entry_id = id;
        r.rank = rk;
        r.name_chars = nm;
        return r;
    endfunction

    function automatic stlf_pkg::t_rsp fx(logic [1:0] st, int id, int cnt, int act);
        stlf_pkg::t_rsp o;
        o = '0;
        o.status = st;
        o.result_id = 7'(id);
        o.entry_count = 7'(cnt);
        o.active_id = 7'(act);
        return o;
    endfunction

    initial begin
        t_row rows [$];
        int   ph;
        table_clear();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows: known answers typed where obvious, others from the shadow table.
        rows.push_back('{mk(stlf_pkg::REQ_GET_RANK, 8'd0, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_MISSING, 0, 0, 0)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_AUTO, 8'd0, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_EMPTY, 0, 0, 0)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_AUTO, 8'd0, 8'd0, 64'h4100_0000_0000_2020), 1'b1,
                         fx(stlf_pkg::ST_EMPTY, 0, 0, 0)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_AUTO, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF),
                         1'b1, fx(stlf_pkg::ST_OK, 1, 1, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_GIVEN, 8'd0, 8'd0, 64'h41), 1'b1,
                         fx(stlf_pkg::ST_FULL, 0, 1, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_GIVEN, 8'd17, 8'd0, 64'h41), 1'b1,
                         fx(stlf_pkg::ST_FULL, 0, 1, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_GIVEN, 8'hFF, 8'd0, 64'h41), 1'b1,
                         fx(stlf_pkg::ST_FULL, 0, 1, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_GIVEN, 8'd1, 8'd0, 64'h41), 1'b1,
                         fx(stlf_pkg::ST_FULL, 0, 1, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_GIVEN, 8'd16, 8'd0, 64'h4243_0044), 1'b1,
                         fx(stlf_pkg::ST_OK, 16, 2, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_ADD_AUTO, 8'd0, 8'd0, 64'h5A20), 1'b1,
                         fx(stlf_pkg::ST_OK, 2, 3, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_GET_ID, 8'd16, 8'd0, '0), 1'b0, '0});
        rows.push_back('{mk(stlf_pkg::REQ_GET_RANK, 8'd0, 8'd2, '0), 1'b0, '0});
        rows.push_back('{mk(stlf_pkg::REQ_GET_RANK, 8'd0, 8'hFF, '0), 1'b1,
                         fx(stlf_pkg::ST_MISSING, 0, 3, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_RANK_OF, 8'd2, 8'd0, '0), 1'b0, '0});
        rows.push_back('{mk(stlf_pkg::REQ_RANK_OF, 8'hFF, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_MISSING, 0, 3, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_SET_ACT, 8'd16, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_OK, 0, 3, 16)});
        rows.push_back('{mk(stlf_pkg::REQ_SET_ACT, 8'd5, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_MISSING, 0, 3, 16)});
        rows.push_back('{mk(stlf_pkg::REQ_DELETE, 8'd16, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_OK, 0, 2, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_DELETE, 8'd16, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_MISSING, 0, 2, 1)});
        rows.push_back('{mk(stlf_pkg::REQ_DELETE, 8'd1, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_OK, 0, 1, 2)});
        rows.push_back('{mk(stlf_pkg::REQ_GET_ID, 8'd0, 8'd0, '0), 1'b1,
                         fx(stlf_pkg::ST_MISSING, 0, 1, 2)});
        rows.push_back('{mk(stlf_pkg::REQ_CLEAR, 8'hAA, 8'h55, 64'h1234), 1'b1,
                         fx(stlf_pkg::ST_OK, 0, 0, 0)});
        foreach (rows[i]) send_req(rows[i].r, rows[i].has_fixed, rows[i].fixed);
        // Fill the table past full to hit the full refusal on both add flavors.
        for (int k = 0; k < 17; k++)
            send_req(mk(stlf_pkg::REQ_ADD_AUTO, 8'd0, 8'd0, 64'h61 + 64'(k)), 1'b0, '0);
        send_req(mk(stlf_pkg::REQ_ADD_GIVEN, 8'd3, 8'd0, 64'h62), 1'b0, '0);

        // Random phases: none, sender idle, receiver stall, both heavy, both light.
        for (int n = 0; n < N_RANDOM; n++) begin
            ph = (n * 5) / N_RANDOM;
            send_idle_pct  = (ph == 1 || ph == 3) ? 54 : (ph == 4 ? 19 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 54 : (ph == 4 ? 19 : 0);
            send_req(pick_req(), 1'b0, '0);
        end

        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/stlf_pkg.sv
rtl/stlf_cell.sv
rtl/slot_table_lowest_free_id_core.sv
verif/tb_slot_table_lowest_free_id_core.sv
